// ===== hw/rtl/vector3_alu_normalize_macros.svh =====
// ----------------------------------------------------------------------------
// vector3_alu_normalize assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_NORMALIZE_MACROS_SVH
`define VECTOR3_ALU_NORMALIZE_MACROS_SVH

// Same-cycle implication.
`define V3N_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define V3N_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg
// Constants, types and saturation helpers of the vector ALU.
// ----------------------------------------------------------------------------
package v3n_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW  = 32;             // component width
	localparam int QW  = DW + FRAC_BITS; // dividend and quotient width
	localparam int PW  = 2 * DW;         // product and radicand width
	localparam int RT  = PW / 2;         // root bits, one per sqrt stage
	localparam int SRW = RT + 4;         // sqrt remainder width

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_DIVS = 3'd4;
	localparam logic [2:0] OP_LEN  = 3'd5;
	localparam logic [2:0] OP_NORM = 3'd6;
	localparam logic [2:0] OP_EQ   = 3'd7;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

	// Side data that travels with each request down the pipeline.
	typedef struct packed {
		logic [2:0]            op;
		logic [2:0][DW-1:0]    r;    // result components
		logic [DW-2:0]         len;  // reported length
		logic                  eq;
		logic                  dz;
		logic                  sat;
		logic [2:0][DW-1:0]    na;   // dividend magnitudes
		logic [2:0]            sn;   // result signs
		logic [2:0][DW-1:0]    dv;   // divisor magnitudes
	} side_t;

	typedef struct packed {
		logic          sat;
		logic [DW-1:0] val;
	} satv_t;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// Apply a sign to a magnitude and clamp to a signed component.
	function automatic satv_t sat_signed(input logic [PW-1:0] m, input logic neg);
		satv_t res;
		if (neg) begin
			if (m > {{(PW-DW){1'b0}}, MIN_NEG}) begin
				res.sat = 1'b1;
				res.val = MIN_NEG;
			end else begin
				res.sat = 1'b0;
				res.val = ~m[DW-1:0] + 1'b1;
			end
		end else begin
			if (m > {{(PW-DW){1'b0}}, MAX_POS}) begin
				res.sat = 1'b1;
				res.val = MAX_POS;
			end else begin
				res.sat = 1'b0;
				res.val = m[DW-1:0];
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/vector3_alu_normalize.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_normalize
// Pipelined three-component Q16.16 vector ALU with length and normalize.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high; busy is always
// low, so one vector per cycle streams in with no gaps. Every request gives
// exactly one result, marked by done for one cycle, in request order. Each
// request passes through the 32-stage digit-by-digit square root, one root bit
// per stage, followed by the 32 + FRAC_BITS stage restoring divider, one
// quotient bit per stage, shared by divide, divide by scalar and normalize.
// All operations take the same path, so results never reorder. The receiver
// has no way to hold results off; it must take done when it comes.
// ----------------------------------------------------------------------------
`include "vector3_alu_normalize_macros.svh"

module vector3_alu_normalize
	import v3n_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           opcode,
	input  logic signed [31:0]   ax,
	input  logic signed [31:0]   ay,
	input  logic signed [31:0]   az,
	input  logic signed [31:0]   bx,
	input  logic signed [31:0]   by_comp,
	input  logic signed [31:0]   bz,
	input  logic signed [31:0]   scalar_in,
	output logic                 done,
	output logic signed [31:0]   rx,
	output logic signed [31:0]   ry,
	output logic signed [31:0]   rz,
	output logic [30:0]          length_out,
	output logic                 is_equal,
	output logic [1:0]           status
);

	// The pipeline never stalls.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: capture the request.
	// ------------------------------------------------------------------
	logic               vld_s1;
	logic [2:0]         op_s1;
	logic [2:0][DW-1:0] a_s1;
	logic [2:0][DW-1:0] b_s1;
	logic [DW-1:0]      sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		a_s1  <= {az, ay, ax};
		b_s1  <= {bz, by_comp, bx};
		sc_s1 <= scalar_in;
	end

	// ------------------------------------------------------------------
	// Stage 2: magnitudes, add/sub with saturation, equality, and one
	// multiplier per lane (A*B for multiply, A*A for the length).
	// ------------------------------------------------------------------
	logic               vld_s2;
	side_t              side_s2;
	logic [2:0][PW-1:0] prod_s2;

	side_t              side_c2;
	logic [2:0][PW-1:0] prod_c2;

	always_comb begin
		logic [DW-1:0] ma;
		logic [DW-1:0] mb;
		logic [DW-1:0] msc;
		logic [DW-1:0] mop;
		logic [DW:0]   sum;
		logic          sq;
		side_c2    = '0;
		side_c2.op = op_s1;
		side_c2.eq = (op_s1 == OP_EQ) && (a_s1 == b_s1);
		msc = mag(sc_s1);
		sq  = op_s1 inside {OP_LEN, OP_NORM};
		for (int i = 0; i < 3; i++) begin
			ma  = mag(a_s1[i]);
			mb  = mag(b_s1[i]);
			mop = sq ? ma : mb;
			prod_c2[i] = PW'(ma) * PW'(mop);
			if (op_s1 == OP_SUB)
				sum = {a_s1[i][DW-1], a_s1[i]} - {b_s1[i][DW-1], b_s1[i]};
			else
				sum = {a_s1[i][DW-1], a_s1[i]} + {b_s1[i][DW-1], b_s1[i]};
			if (op_s1 inside {OP_ADD, OP_SUB}) begin
				if (sum[DW] != sum[DW-1]) begin
					side_c2.r[i] = sum[DW] ? MIN_NEG : MAX_POS;
					side_c2.sat  = 1'b1;
				end else begin
					side_c2.r[i] = sum[DW-1:0];
				end
			end
			side_c2.na[i] = ma;
			if (op_s1 == OP_NORM)
				side_c2.sn[i] = a_s1[i][DW-1];
			else if (op_s1 == OP_DIVS)
				side_c2.sn[i] = a_s1[i][DW-1] ^ sc_s1[DW-1];
			else
				side_c2.sn[i] = a_s1[i][DW-1] ^ b_s1[i][DW-1];
			side_c2.dv[i] = (op_s1 == OP_DIVS) ? msc : mb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_c2;
		prod_s2 <= prod_c2;
	end

	// ------------------------------------------------------------------
	// Stage 3: scale and clamp products; first add of the squares.
	// ------------------------------------------------------------------
	logic          vld_s3;
	side_t         side_s3;
	logic [PW:0]   sxy_s3;
	logic [PW-1:0] pz_s3;

	side_t side_c3;

	always_comb begin
		satv_t sv;
		side_c3 = side_s2;
		for (int i = 0; i < 3; i++) begin
			sv = sat_signed(prod_s2[i] >> FRAC_BITS, side_s2.sn[i]);
			if (side_s2.op == OP_MUL) begin
				side_c3.r[i] = sv.val;
				side_c3.sat  = side_c3.sat | sv.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c3;
		sxy_s3  <= {1'b0, prod_s2[0]} + {1'b0, prod_s2[1]};
		pz_s3   <= prod_s2[2];
	end

	// ------------------------------------------------------------------
	// Stage 4: full sum of squares. Three squares stay below 2^64.
	// ------------------------------------------------------------------
	logic          vld_s4;
	side_t         side_s4;
	logic [PW-1:0] rad_s4;
	logic [PW:0]   sum_c4;

	assign sum_c4 = sxy_s3 + {1'b0, pz_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		rad_s4  <= sum_c4[PW-1:0];
	end

	// ------------------------------------------------------------------
	// Stage 5: square root, one root bit per stage.
	// ------------------------------------------------------------------
	logic [RT-1:0]  vld_s5;
	side_t          side_s5 [RT];
	logic [SRW-1:0] rem_s5  [RT];
	logic [RT-1:0]  root_s5 [RT];
	logic [PW-1:0]  rad_s5  [RT];

	for (genvar k = 0; k < RT; k++) begin : g_sqrt
		logic           vin;
		side_t          sin;
		logic [SRW-1:0] rin;
		logic [RT-1:0]  qin;
		logic [PW-1:0]  din;
		logic [SRW-1:0] rsh;
		logic [SRW-1:0] trial;

		if (k == 0) begin : g_first
			assign vin = vld_s4;
			assign sin = side_s4;
			assign rin = '0;
			assign qin = '0;
			assign din = rad_s4;
		end else begin : g_next
			assign vin = vld_s5[k-1];
			assign sin = side_s5[k-1];
			assign rin = rem_s5[k-1];
			assign qin = root_s5[k-1];
			assign din = rad_s5[k-1];
		end

		// bring down the next two radicand bits
		assign rsh   = {rin[SRW-3:0], din[PW-1 -: 2]};
		assign trial = SRW'({qin, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s5[k] <= 1'b0;
			else         vld_s5[k] <= vin;
		end

		always_ff @(posedge clk) begin
			side_s5[k] <= sin;
			rad_s5[k]  <= din << 2;
			if (rsh >= trial) begin
				rem_s5[k]  <= rsh - trial;
				root_s5[k] <= {qin[RT-2:0], 1'b1};
			end else begin
				rem_s5[k]  <= rsh;
				root_s5[k] <= {qin[RT-2:0], 1'b0};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: report the length; normalize divides by it.
	// ------------------------------------------------------------------
	logic  vld_s6;
	side_t side_s6;
	side_t side_c6;

	always_comb begin
		logic [RT-1:0] len;
		len     = root_s5[RT-1];
		side_c6 = side_s5[RT-1];
		if (side_c6.op inside {OP_LEN, OP_NORM}) begin
			side_c6.len = len[RT-1] ? {(DW-1){1'b1}} : len[DW-2:0];
			// only the length operation flags a clamped length
			if (side_c6.op == OP_LEN && len[RT-1])
				side_c6.sat = 1'b1;
		end
		if (side_c6.op == OP_NORM) begin
			side_c6.dz = (len == '0);
			for (int i = 0; i < 3; i++)
				side_c6.dv[i] = len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5[RT-1];
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_c6;
	end

	// ------------------------------------------------------------------
	// Stage 7: restoring divider, one quotient bit per stage, three lanes.
	// The dividend register shifts out dividend bits and takes in quotient
	// bits, so it holds the quotient after the last stage.
	// ------------------------------------------------------------------
	logic [QW-1:0]      vld_s7;
	side_t              side_s7 [QW];
	logic [2:0][DW-1:0] drem_s7 [QW];
	logic [2:0][QW-1:0] dn_s7   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic  vin;
		side_t sin;

		if (j == 0) begin : g_first
			assign vin = vld_s6;
			assign sin = side_s6;
		end else begin : g_next
			assign vin = vld_s7[j-1];
			assign sin = side_s7[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s7[j] <= 1'b0;
			else         vld_s7[j] <= vin;
		end

		always_ff @(posedge clk) begin
			side_s7[j] <= sin;
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [DW-1:0] rin;
			logic [QW-1:0] nin;
			logic [DW:0]   rsh;
			logic [DW:0]   diff;

			if (j == 0) begin : g_first
				assign rin = '0;
				assign nin = {sin.na[i], {FRAC_BITS{1'b0}}};
			end else begin : g_next
				assign rin = drem_s7[j-1][i];
				assign nin = dn_s7[j-1][i];
			end

			assign rsh  = {rin, nin[QW-1]};
			assign diff = rsh - {1'b0, sin.dv[i]};

			always_ff @(posedge clk) begin
				if (rsh >= {1'b0, sin.dv[i]}) begin
					drem_s7[j][i] <= diff[DW-1:0];
					dn_s7[j][i]   <= {nin[QW-2:0], 1'b1};
				end else begin
					drem_s7[j][i] <= rsh[DW-1:0];
					dn_s7[j][i]   <= {nin[QW-2:0], 1'b0};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: sign and clamp quotients, resolve zero divisors,
	// encode status. Divide by zero outranks saturation.
	// ------------------------------------------------------------------
	side_t              side_c8;
	logic [2:0][QW-1:0] quo_c8;
	logic [1:0]         st_c8;

	assign quo_c8 = dn_s7[QW-1];

	always_comb begin
		satv_t sv;
		side_c8 = side_s7[QW-1];
		case (side_c8.op)
			OP_DIV, OP_DIVS: begin
				for (int i = 0; i < 3; i++) begin
					sv = sat_signed(PW'(quo_c8[i]), side_c8.sn[i]);
					if (side_c8.dv[i] == '0) begin
						side_c8.dz = 1'b1;
						if (side_c8.na[i] == '0)   side_c8.r[i] = '0;
						else if (side_c8.sn[i])    side_c8.r[i] = MIN_NEG;
						else                       side_c8.r[i] = MAX_POS;
					end else begin
						side_c8.r[i] = sv.val;
						side_c8.sat  = side_c8.sat | sv.sat;
					end
				end
			end
			OP_NORM: begin
				for (int i = 0; i < 3; i++) begin
					sv = sat_signed(PW'(quo_c8[i]), side_c8.sn[i]);
					// zero length leaves the components at zero
					if (!side_c8.dz) begin
						side_c8.r[i] = sv.val;
						side_c8.sat  = side_c8.sat | sv.sat;
					end
				end
			end
			default: begin
			end
		endcase
		if (side_c8.dz)       st_c8 = ST_DZ;
		else if (side_c8.sat) st_c8 = ST_SAT;
		else                  st_c8 = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s7[QW-1];
	end

	always_ff @(posedge clk) begin
		rx         <= side_c8.r[0];
		ry         <= side_c8.r[1];
		rz         <= side_c8.r[2];
		length_out <= side_c8.len;
		is_equal   <= side_c8.eq;
		status     <= st_c8;
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`V3N_ASSERT_NXT(a_take, start && !busy, vld_s1, "accepted request did not enter the pipe")
	`V3N_ASSERT_IMP(a_code, done, status == ST_OK || status == ST_DZ || status == ST_SAT, "bad status code")
	`V3N_ASSERT_IMP(a_eq, done && is_equal, status == ST_OK && length_out == '0 && rx == '0, "equal result carries other data")

endmodule
